// ===== design/rbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types, codes and limits of the ring buffer slot manager.
// ----------------------------------------------------------------------------
package rbm_pkg;

	localparam int MAX_SLOTS   = 256;
	localparam int MAX_READERS = 4;
	localparam int RDR_W       = $clog2(MAX_READERS);
	localparam int CUR_W       = 32;
	localparam int CAP_W       = 9;
	localparam int EB_W        = 13;
	localparam int LIM_W       = 3;
	localparam int SLOT_W      = 8;
	localparam int OFS_W       = 20;
	localparam int ST_W        = 3;
	localparam int ASG_W       = 3;
	localparam int RDY_W       = 8;
	localparam int IN_W        = 8;
	localparam int OUT_W       = 48;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int EB_MAX      = 4096;

	// operation codes
	localparam logic [2:0] OP_ACQ_WRITE = 3'd0;
	localparam logic [2:0] OP_COMMIT    = 3'd1;
	localparam logic [2:0] OP_ABORT     = 3'd2;
	localparam logic [2:0] OP_ATTACH    = 3'd3;
	localparam logic [2:0] OP_FREEZE    = 3'd4;
	localparam logic [2:0] OP_ACQ_READ  = 3'd5;
	localparam logic [2:0] OP_RELEASE   = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK            = 3'd0;
	localparam logic [ST_W-1:0] ST_INVALID       = 3'd1;
	localparam logic [ST_W-1:0] ST_BUSY          = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW      = 3'd3;
	localparam logic [ST_W-1:0] ST_WOULD_BLOCK   = 3'd4;
	localparam logic [ST_W-1:0] ST_NOT_SUPPORTED = 3'd5;

	localparam logic [ASG_W-1:0] NO_READER = 3'd4;

	// bus kinds
	localparam logic [1:0] KIND_LATEST = 2'd0;
	localparam logic [1:0] KIND_QUEUE  = 2'd1;
	localparam logic [1:0] KIND_SIGNAL = 2'd2;
	localparam logic [1:0] KIND_BLOCK  = 2'd3;

	// register indexes
	localparam logic [1:0] REG_KIND  = 2'd0;
	localparam logic [1:0] REG_CAP   = 2'd1;
	localparam logic [1:0] REG_EB    = 2'd2;
	localparam logic [1:0] REG_LIMIT = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [CAP_W-1:0] cap;
		logic [EB_W-1:0]  eb;
		logic [LIM_W-1:0] limit;
		logic             ok;
		logic             wr;
	} cfg_t;

	typedef struct packed {
		logic [CUR_W-1:0] cursor;
		logic [CUR_W-1:0] laps;
	} rd_entry_t;

endpackage

// ===== design/spmc_ring_buffer_manager.sv =====
// ----------------------------------------------------------------------------
// spmc_ring_buffer_manager
// Slot manager for a single-writer, multi-reader zero-copy buffer.
// ----------------------------------------------------------------------------
// Sequence: an accepted word passes the execute and finish states; queue/signal acquires
//   also run the remainder state (32-step remainder unit for the slot) before the output.
// Flow: one word at a time; the next word is taken the cycle after the result is read.
// Reset and every register write clear the cursors, attach marks and slots;
//   reader entries carry valid bits, so no clearing pass is needed.
module spmc_ring_buffer_manager (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rbm_pkg::IN_W-1:0]    s_tdata,  // mode[2:0], reader[4:3]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rbm_pkg::OUT_W-1:0]   m_tdata,  // status[2:0], slot[10:3],
	                                              // slot_offset[30:11],
	                                              // assigned_reader[33:31],
	                                              // avail_cnt[41:34]
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rbm_pkg::ADDR_W-1:0]  paddr,
	input  logic [rbm_pkg::DATA_W-1:0]  pwdata,
	output logic [rbm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import rbm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_MOD  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	cfg_t cfg;

	logic [2:0]             state_q;
	logic [CUR_W-1:0]       wc_q;
	logic [MAX_READERS-1:0] mask_q;
	logic [MAX_READERS-1:0] valid_q;
	logic [LIM_W-1:0]       nattached_q;
	logic                   frozen_q;
	logic                   wopen_q;
	logic                   pub_vld_q;
	logic [1:0]             pub_q;
	logic                   rdg_vld_q;
	logic [1:0]             rdg_q;
	logic [1:0]             wslot_q;

	logic [2:0]             op_s1;
	logic [RDR_W-1:0]       rd_s1;

	logic [ST_W-1:0]        status_s2;
	logic [ASG_W-1:0]       asg_s2;
	logic [CUR_W-1:0]       rc_s2;
	logic                   cfgok_s2;
	logic                   has_slot_s2;
	logic [SLOT_W-1:0]      slot_s2;

	logic [ST_W-1:0]        status_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [OFS_W-1:0]       ofs_q;
	logic [ASG_W-1:0]       asg_q;
	logic [RDY_W-1:0]       rdy_q;

	logic                   in_acc;
	logic [2:0]             in_mode;
	logic [RDR_W-1:0]       in_rd;
	logic [RDR_W-1:0]       ram_raddr;
	rd_entry_t              ram_rdata;
	rd_entry_t              cur;
	logic                   ram_we;
	logic [RDR_W-1:0]       ram_waddr;
	rd_entry_t              ram_wdata;

	logic                   mod_start;
	logic                   mod_done;
	logic [CAP_W-1:0]       mod_rem;

	// result of the execute step
	logic [ST_W-1:0]        ex_status;
	logic [ASG_W-1:0]       ex_asg;
	logic                   ex_need_mod;
	logic                   ex_direct;
	logic [1:0]             ex_dslot;
	logic [CUR_W-1:0]       ex_mod_arg;
	logic [CUR_W-1:0]       ex_rc_after;
	logic [CUR_W-1:0]       nx_wc;
	logic                   nx_wopen;
	logic                   nx_frozen;
	logic                   nx_pub_vld;
	logic [1:0]             nx_pub;
	logic                   nx_rdg_vld;
	logic [1:0]             nx_rdg;
	logic [1:0]             nx_wslot;
	logic [LIM_W-1:0]       nx_nattached;
	logic [MAX_READERS-1:0] nx_mask;
	logic [MAX_READERS-1:0] nx_valid;

	logic [CAP_W-1:0]       cap_m1;
	logic [CUR_W-1:0]       diff;
	logic                   rd_in_lim;
	logic                   rd_ok;
	logic                   free_found;
	logic [RDR_W-1:0]       free_idx;
	logic [1:0]             pick;
	logic [CUR_W-1:0]       fin_diff;
	logic [RDY_W-1:0]       fin_rdy;
	logic [SLOT_W+EB_W-1:0] fin_prod;

	rbm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign in_acc   = s_tvalid & s_tready;
	assign in_mode  = s_tdata[2:0];
	assign in_rd    = s_tdata[4:3];

	// queue write admission looks at reader 0
	assign ram_raddr = (in_mode == OP_ACQ_WRITE && cfg.kind == KIND_QUEUE) ?
		RDR_W'(0) : in_rd;

	rbm_reader_ram u_ram (
		.clk   (clk),
		.re    (in_acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata)
	);

	rbm_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (ex_mod_arg),
		.divisor   (cfg.cap),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// entries never written since clear read as zero
	logic [RDR_W-1:0] rd_addr_s1;
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= in_mode;
			rd_s1      <= in_rd;
			rd_addr_s1 <= ram_raddr;
		end
	end
	assign cur = valid_q[rd_addr_s1] ? ram_rdata : '0;

	assign cap_m1    = cfg.cap - 1'b1;
	assign diff      = wc_q - cur.cursor;
	assign rd_in_lim = ({1'b0, rd_s1} < cfg.limit);
	assign rd_ok     = rd_in_lim & mask_q[rd_s1];

	// lowest free reader index below the limit
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_READERS - 1; i >= 0; i--) begin
			if (LIM_W'(i) < cfg.limit && !mask_q[i]) begin
				free_found = 1'b1;
				free_idx   = RDR_W'(i);
			end
		end
	end

	// triple buffer: first slot neither published nor being read
	always_comb begin
		pick = 2'd0;
		for (int i = 2; i >= 0; i--) begin
			if (!(pub_vld_q && pub_q == 2'(i)) && !(rdg_vld_q && rdg_q == 2'(i))) begin
				pick = 2'(i);
			end
		end
	end

	// execute one operation
	always_comb begin
		ex_status    = ST_INVALID;
		ex_asg       = NO_READER;
		ex_need_mod  = 1'b0;
		ex_direct    = 1'b0;
		ex_dslot     = 2'd0;
		ex_mod_arg   = cur.cursor;
		ex_rc_after  = cur.cursor;
		nx_wc        = wc_q;
		nx_wopen     = wopen_q;
		nx_frozen    = frozen_q;
		nx_pub_vld   = pub_vld_q;
		nx_pub       = pub_q;
		nx_rdg_vld   = rdg_vld_q;
		nx_rdg       = rdg_q;
		nx_wslot     = wslot_q;
		nx_nattached = nattached_q;
		nx_mask      = mask_q;
		nx_valid     = valid_q;
		ram_we       = 1'b0;
		ram_waddr    = rd_s1;
		ram_wdata    = cur;
		if (cfg.ok) begin
			case (op_s1)
				OP_ACQ_WRITE: begin
					if (cfg.kind == KIND_BLOCK) begin
						ex_status = ST_NOT_SUPPORTED;
					end else if (wopen_q) begin
						ex_status = ST_BUSY;
					end else if (cfg.kind == KIND_LATEST) begin
						nx_wslot  = pick;
						nx_wopen  = 1'b1;
						ex_direct = 1'b1;
						ex_dslot  = pick;
						ex_status = ST_OK;
					end else if (cfg.kind == KIND_QUEUE && diff >= CUR_W'(cap_m1)) begin
						ex_status = ST_OVERFLOW;
					end else begin
						nx_wopen    = 1'b1;
						ex_need_mod = 1'b1;
						ex_mod_arg  = wc_q;
						ex_status   = ST_OK;
					end
				end
				OP_COMMIT: begin
					if (cfg.kind == KIND_BLOCK) begin
						ex_status = ST_NOT_SUPPORTED;
					end else if (wopen_q) begin
						if (cfg.kind == KIND_LATEST) begin
							nx_pub_vld = 1'b1;
							nx_pub     = wslot_q;
						end else begin
							nx_wc = wc_q + 1'b1;
						end
						nx_wopen  = 1'b0;
						ex_status = ST_OK;
					end
				end
				OP_ABORT: begin
					if (wopen_q) begin
						nx_wopen  = 1'b0;
						ex_status = ST_OK;
					end
				end
				OP_ATTACH: begin
					if (cfg.kind == KIND_BLOCK) begin
						ex_status = ST_NOT_SUPPORTED;
					end else if (frozen_q) begin
						ex_status = ST_BUSY;
					end else if (cfg.kind == KIND_LATEST) begin
						if (nattached_q == '0) begin
							nx_nattached = nattached_q + 1'b1;
							ex_status    = ST_OK;
						end
					end else if (!((cfg.kind == KIND_QUEUE && nattached_q != '0) ||
							nattached_q >= cfg.limit) && free_found) begin
						ram_we           = 1'b1;
						ram_waddr        = free_idx;
						ram_wdata.cursor = wc_q;
						ram_wdata.laps   = '0;
						nx_valid[free_idx] = 1'b1;
						nx_mask[free_idx]  = 1'b1;
						nx_nattached     = nattached_q + 1'b1;
						ex_asg           = ASG_W'(free_idx);
						ex_status        = ST_OK;
						if (free_idx == rd_s1) begin
							ex_rc_after = wc_q;
						end
					end
				end
				OP_FREEZE: begin
					nx_frozen = 1'b1;
					ex_status = ST_OK;
				end
				OP_ACQ_READ: begin
					if (cfg.kind == KIND_LATEST) begin
						if (!pub_vld_q) begin
							ex_status = ST_WOULD_BLOCK;
						end else begin
							nx_rdg_vld = 1'b1;
							nx_rdg     = pub_q;
							ex_direct  = 1'b1;
							ex_dslot   = pub_q;
							ex_status  = ST_OK;
						end
					end else if (!rd_ok) begin
						ex_status = ST_INVALID;
					end else if (diff == '0) begin
						ex_status = ST_WOULD_BLOCK;
					end else begin
						ex_need_mod = 1'b1;
						if (diff >= CUR_W'(cfg.cap)) begin
							ex_rc_after      = wc_q - CUR_W'(cap_m1);
							ex_mod_arg       = ex_rc_after;
							ram_we           = 1'b1;
							ram_wdata.cursor = ex_rc_after;
							ram_wdata.laps   = (&cur.laps) ? cur.laps : cur.laps + 1'b1;
							nx_valid[rd_s1]  = 1'b1;
							ex_status        = ST_OVERFLOW;
						end else begin
							ex_status = ST_OK;
						end
					end
				end
				OP_RELEASE: begin
					if (cfg.kind == KIND_LATEST) begin
						nx_rdg_vld = 1'b0;
						ex_status  = ST_OK;
					end else if (rd_ok) begin
						ex_rc_after      = cur.cursor + 1'b1;
						ram_we           = 1'b1;
						ram_wdata.cursor = ex_rc_after;
						nx_valid[rd_s1]  = 1'b1;
						ex_status        = ST_OK;
					end
				end
				default: ex_status = ST_INVALID;
			endcase
		end
		if (state_q != S_EXEC) begin
			ram_we = 1'b0;
		end
	end

	assign mod_start = (state_q == S_EXEC) && ex_need_mod;

	// sequencer and run-time state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wc_q        <= '0;
			mask_q      <= '0;
			valid_q     <= '0;
			nattached_q <= '0;
			frozen_q    <= 1'b0;
			wopen_q     <= 1'b0;
			pub_vld_q   <= 1'b0;
			pub_q       <= '0;
			rdg_vld_q   <= 1'b0;
			rdg_q       <= '0;
			wslot_q     <= '0;
		end else if (cfg.wr) begin
			wc_q        <= '0;
			mask_q      <= '0;
			valid_q     <= '0;
			nattached_q <= '0;
			frozen_q    <= 1'b0;
			wopen_q     <= 1'b0;
			pub_vld_q   <= 1'b0;
			rdg_vld_q   <= 1'b0;
			wslot_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_EXEC;
				end
				S_EXEC: begin
					wc_q        <= nx_wc;
					mask_q      <= nx_mask;
					valid_q     <= nx_valid;
					nattached_q <= nx_nattached;
					frozen_q    <= nx_frozen;
					wopen_q     <= nx_wopen;
					pub_vld_q   <= nx_pub_vld;
					pub_q       <= nx_pub;
					rdg_vld_q   <= nx_rdg_vld;
					rdg_q       <= nx_rdg;
					wslot_q     <= nx_wslot;
					state_q     <= ex_need_mod ? S_MOD : S_FIN;
				end
				S_MOD: begin
					if (mod_done) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the execute results for the finish step
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_s2   <= ex_status;
			asg_s2      <= ex_asg;
			rc_s2       <= ex_rc_after;
			cfgok_s2    <= cfg.ok;
			has_slot_s2 <= ex_direct;
			slot_s2     <= SLOT_W'(ex_dslot);
		end else if (state_q == S_MOD && mod_done) begin
			has_slot_s2 <= 1'b1;
			slot_s2     <= mod_rem[SLOT_W-1:0];
		end
	end

	// ready count after the operation, clipped to capacity minus one
	assign fin_diff = wc_q - rc_s2;
	always_comb begin
		if (!cfgok_s2) begin
			fin_rdy = '0;
		end else if (cfg.kind == KIND_LATEST) begin
			fin_rdy = RDY_W'(pub_vld_q);
		end else if (!rd_in_lim) begin
			fin_rdy = '0;
		end else if (fin_diff > CUR_W'(cap_m1)) begin
			fin_rdy = cap_m1[RDY_W-1:0];
		end else begin
			fin_rdy = fin_diff[RDY_W-1:0];
		end
	end

	assign fin_prod = (SLOT_W+EB_W)'(has_slot_s2 ? slot_s2 : '0) *
		(SLOT_W+EB_W)'(cfg.eb);

	// load the output word
	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			status_q <= status_s2;
			slot_q   <= has_slot_s2 ? slot_s2 : '0;
			ofs_q    <= fin_prod[OFS_W-1:0];
			asg_q    <= asg_s2;
			rdy_q    <= fin_rdy;
		end
	end

	assign m_tdata = {6'b0, rdy_q, asg_q, ofs_q, slot_q, status_q};

endmodule

// ===== design/rbm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rbm_cfg_regs
// Configuration registers behind the APB port and the validity check.
// ----------------------------------------------------------------------------
module rbm_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbm_pkg::ADDR_W-1:0] paddr,
	input  logic [rbm_pkg::DATA_W-1:0] pwdata,
	output logic [rbm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rbm_pkg::cfg_t              cfg
);
	import rbm_pkg::*;

	logic [1:0]       kind_q;
	logic [CAP_W-1:0] cap_q;
	logic [EB_W-1:0]  eb_q;
	logic [LIM_W-1:0] limit_q;
	logic             wr_en;
	logic [1:0]       idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[3:2];

	// update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_QUEUE;
			cap_q   <= CAP_W'(4);
			eb_q    <= EB_W'(4);
			limit_q <= LIM_W'(1);
		end else if (wr_en) begin
			case (idx)
				REG_KIND:  kind_q  <= pwdata[1:0];
				REG_CAP:   cap_q   <= pwdata[CAP_W-1:0];
				REG_EB:    eb_q    <= pwdata[EB_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIM_W-1:0];
				default:   kind_q  <= kind_q;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_KIND:  prdata = DATA_W'(kind_q);
			REG_CAP:   prdata = DATA_W'(cap_q);
			REG_EB:    prdata = DATA_W'(eb_q);
			REG_LIMIT: prdata = DATA_W'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// check the combination
	always_comb begin
		cfg.kind  = kind_q;
		cfg.cap   = cap_q;
		cfg.eb    = eb_q;
		cfg.limit = limit_q;
		cfg.wr    = wr_en;
		cfg.ok    = 1'b1;
		if (eb_q == '0 || eb_q > EB_W'(EB_MAX)) cfg.ok = 1'b0;
		if (cap_q < CAP_W'(2) || cap_q > CAP_W'(MAX_SLOTS)) cfg.ok = 1'b0;
		if (limit_q == '0 || limit_q > LIM_W'(MAX_READERS)) cfg.ok = 1'b0;
		if (kind_q == KIND_LATEST && cap_q < CAP_W'(3)) cfg.ok = 1'b0;
		if (kind_q == KIND_QUEUE && limit_q != LIM_W'(1)) cfg.ok = 1'b0;
	end

endmodule

// ===== design/rbm_reader_ram.sv =====
// ----------------------------------------------------------------------------
// rbm_reader_ram
// Per-reader cursor and lap count store, one write and one registered read.
// ----------------------------------------------------------------------------
module rbm_reader_ram (
	input  logic                      clk,
	input  logic                      re,
	input  logic [rbm_pkg::RDR_W-1:0] raddr,
	output rbm_pkg::rd_entry_t        rdata,
	input  logic                      we,
	input  logic [rbm_pkg::RDR_W-1:0] waddr,
	input  rbm_pkg::rd_entry_t        wdata
);
	import rbm_pkg::*;

	rd_entry_t mem [MAX_READERS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/rbm_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rbm_mod_unit
// Restoring remainder of a cursor by the capacity, one bit per cycle.
// ----------------------------------------------------------------------------
module rbm_mod_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rbm_pkg::CUR_W-1:0] dividend,
	input  logic [rbm_pkg::CAP_W-1:0] divisor,
	output logic                      done,
	output logic [rbm_pkg::CAP_W-1:0] remainder
);
	import rbm_pkg::*;

	localparam int CNT_W = $clog2(CUR_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CUR_W-1:0] dvd_q;
	logic [CAP_W-1:0] div_q;
	logic [CAP_W-1:0] rem_q;
	logic             done_q;
	logic [CAP_W:0]   trial;

	// shift the next dividend bit into the partial remainder
	assign trial     = {rem_q, dvd_q[CUR_W-1]};
	assign done      = done_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CUR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CUR_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= CAP_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[CAP_W-1:0];
			end
		end
	end

endmodule

// ===== design/rbm_checker.sv =====
// ----------------------------------------------------------------------------
// rbm_checker
// Port-level checks of the slot manager, bound to the top level.
// ----------------------------------------------------------------------------
module rbm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [rbm_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [rbm_pkg::OUT_W-1:0] m_tdata
);
	import rbm_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	// one word in flight at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result waits");

	// no result in the cycle after an accept
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid && !s_tready)
		else $error("accept did not start work");

	// slot only with ok or overflow
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != ST_OK && m_tdata[2:0] != ST_OVERFLOW
		|-> m_tdata[30:3] == '0)
		else $error("slot given with a failing status");

endmodule

bind spmc_ring_buffer_manager rbm_checker u_rbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
